/* hdl/chtbl_pkg.sv */
// Shared types, codes and field widths of the chained hash table.
`default_nettype none
package chtbl_pkg;

  localparam int unsigned BUCKETS_DEF = 16;
  localparam int unsigned ENTRIES_DEF = 32;

  localparam int unsigned KEY_W  = 31;
  localparam int unsigned ROLE_W = 3;
  localparam int unsigned NAME0_W = 64;
  localparam int unsigned NAME1_W = 64;
  localparam int unsigned NAME2_W = 32;
  localparam int unsigned REC_W = KEY_W + ROLE_W + NAME0_W + NAME1_W + NAME2_W;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned FILL_W = 6;
  localparam int unsigned IN_DATA_W  = 200;
  localparam int unsigned OUT_DATA_W = 224;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_DUP      = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_HASH,
    S_HEAD,
    S_HWAIT,
    S_WALK,
    S_FRESH,
    S_WR1,
    S_WR2,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

/* hdl/chained_hash_table.sv */
// Top level of the chained hash table: command sequencer, memories and result register.
`default_nettype none
// A hash table of records (key, role code, 20-byte name) with separate chaining in a
// pool of ENTRIES entries and a free stack linked through the entry links. One command
// is worked at a time. The bucket heads, the entry links and the record contents sit in
// three synchronous memories with registered read data, and one chain entry is
// examined per cycle. A command runs through accept, bucket head read, head data and
// result, with a walk over the chain entries visited (up to ENTRIES), a reciprocal
// multiply and remainder correction when BUCKETS is not a power of two, and the write
// steps for insert and delete. An insert refused for a full pool goes from accept
// straight to result. After reset, and for every clear command, a clearing pass over
// every bucket head and entry link rebuilds the heads and the free stack; no item is taken
// during it. The result register lets the next item be taken while a result still
// waits on the output.
module chained_hash_table
  import chtbl_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // key[30:0], role_code[33:31], name_part0[97:34], name_part1[161:98],
  // name_part2[193:162], zero fill above
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // slot[5:0], prev_slot[11:6], found_key[42:12], found_role[45:43],
  // found_name0[109:46], found_name1[173:110], found_name2[205:174],
  // next_link[211:206], fill_count[217:212], zero fill above
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status[1:0]
  output logic [1:0]                 out_tuser
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW = EW + 1;           // link: msb set means end of list
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned CLR_N = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int unsigned XW = $clog2(CLR_N);
  localparam bit BPOW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [LW-1:0] NULL_LINK = {1'b1, {EW{1'b0}}};
  // Reciprocal of BUCKETS scaled by 2^RS; the quotient estimate is low by at most one.
  localparam int unsigned RS = KEY_W + BW;
  localparam logic [31:0] RECIP = 32'((64'd1 << RS) / 64'(BUCKETS));
  localparam logic [BW:0] BKT = (BW + 1)'(BUCKETS);

  // Memories.
  logic [LW-1:0]    heads_mem [BUCKETS];
  logic [LW-1:0]    link_mem  [ENTRIES];
  logic [REC_W-1:0] rec_mem   [ENTRIES];

  logic [LW-1:0]    head_q;
  logic [LW-1:0]    link_q;
  logic [REC_W-1:0] rec_q;

  logic             heads_we, link_we, rec_we;
  logic [BW-1:0]    heads_wa;
  logic [LW-1:0]    heads_wd, link_wd;
  logic [EW-1:0]    link_wa, rec_wa, rd_addr;

  // Control and datapath registers.
  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [REC_W-1:0] in_rec_r, in_rec_nxt;
  logic [BW-1:0]    bucket_r, bucket_nxt;
  logic             hash_ph_r, hash_ph_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [EW-1:0]    cur_r, cur_nxt;
  logic [LW-1:0]    pred_r, pred_nxt;
  logic [EW-1:0]    steps_r, steps_nxt;
  logic [XW-1:0]    clr_idx_r, clr_idx_nxt;
  logic             clr_resp_r, clr_resp_nxt;
  logic [LW-1:0]    free_r, free_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Result held until the output register is free.
  status_t          res_status_r, res_status_nxt;
  logic [LW-1:0]    res_slot_r, res_slot_nxt;
  logic [LW-1:0]    res_pred_r, res_pred_nxt;
  logic [LW-1:0]    res_link_r, res_link_nxt;
  logic [REC_W-1:0] res_rec_r, res_rec_nxt;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [1:0]            out_tuser_r;

  logic              accept;
  logic              out_free;
  logic [BW:0]       rem_est;
  logic              key_hit;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [LW-1:0] l);
    logic [31:0] wide;
    wide = 32'(l[EW-1:0]);
    return l[LW-1] ? {SLOT_W{1'b1}} : wide[SLOT_W-1:0];
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  // Remainder from the quotient estimate, in [0, 2*BUCKETS); only the low bits matter.
  assign rem_est   = key_r[BW:0] - (BW + 1)'(prod_r[RS +: BW + 1] * BKT);
  assign key_hit   = (rec_q[KEY_W-1:0] == key_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (cmd_t'(in_tuser) == CMD_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (cmd_t'(in_tuser) == CMD_INSERT &&
                       (count_r >= CW'(ENTRIES) || free_r[LW-1])) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = BPOW2 ? S_HEAD : S_HASH;
          end
        end
      end
      S_CLEAR: begin
        if (clr_idx_r == XW'(CLR_N - 1)) begin
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_HASH: begin
        if (hash_ph_r) state_nxt = S_HEAD;
      end
      S_HEAD: state_nxt = S_HWAIT;
      S_HWAIT: begin
        if (!head_q[LW-1])            state_nxt = S_WALK;
        else if (cmd_r == CMD_INSERT) state_nxt = S_FRESH;
        else                          state_nxt = S_RESP;
      end
      S_WALK: begin
        if (key_hit) begin
          state_nxt = (cmd_r == CMD_DELETE) ? S_WR1 : S_RESP;
        end else if (link_q[LW-1] || steps_r == EW'(ENTRIES - 1)) begin
          state_nxt = (cmd_r == CMD_INSERT) ? S_FRESH : S_RESP;
        end
      end
      S_FRESH: state_nxt = S_WR1;
      S_WR1:   state_nxt = (cmd_r == CMD_DELETE) ? S_WR2 : S_RESP;
      S_WR2:   state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    in_rec_nxt     = in_rec_r;
    bucket_nxt     = bucket_r;
    hash_ph_nxt    = hash_ph_r;
    prod_nxt       = prod_r;
    cur_nxt        = cur_r;
    pred_nxt       = pred_r;
    steps_nxt      = steps_r;
    clr_idx_nxt    = clr_idx_r;
    clr_resp_nxt   = clr_resp_r;
    free_nxt       = free_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_pred_nxt   = res_pred_r;
    res_link_nxt   = res_link_r;
    res_rec_nxt    = res_rec_r;
    heads_we = 1'b0;
    heads_wa = bucket_r;
    heads_wd = NULL_LINK;
    link_we  = 1'b0;
    link_wa  = cur_r;
    link_wd  = NULL_LINK;
    rec_we   = 1'b0;
    rec_wa   = free_r[EW-1:0];
    rd_addr  = cur_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = cmd_t'(in_tuser);
          key_nxt        = in_tdata[KEY_W-1:0];
          in_rec_nxt     = in_tdata[REC_W-1:0];
          bucket_nxt     = BPOW2 ? in_tdata[BW-1:0] : '0;
          hash_ph_nxt    = 1'b0;
          pred_nxt       = NULL_LINK;
          steps_nxt      = '0;
          clr_idx_nxt    = '0;
          clr_resp_nxt   = 1'b1;
          res_status_nxt = (cmd_t'(in_tuser) == CMD_INSERT) ? ST_FULL : ST_OK;
          res_slot_nxt   = NULL_LINK;
          res_pred_nxt   = NULL_LINK;
          res_link_nxt   = NULL_LINK;
          res_rec_nxt    = '0;
        end
      end
      S_CLEAR: begin
        heads_we = (32'(clr_idx_r) < BUCKETS);
        heads_wa = clr_idx_r[BW-1:0];
        heads_wd = NULL_LINK;
        link_we  = (32'(clr_idx_r) < ENTRIES);
        link_wa  = clr_idx_r[EW-1:0];
        link_wd  = (32'(clr_idx_r) == ENTRIES - 1) ? NULL_LINK
                                                   : LW'(32'(clr_idx_r) + 1);
        clr_idx_nxt = clr_idx_r + 1'b1;
        free_nxt    = '0;
        count_nxt   = '0;
      end
      S_HASH: begin
        // The first phase multiplies by the reciprocal, the second corrects the remainder.
        if (!hash_ph_r) begin
          prod_nxt = 64'(key_r) * 64'(RECIP);
        end else begin
          bucket_nxt = (rem_est >= BKT) ? BW'(rem_est - BKT) : BW'(rem_est);
        end
        hash_ph_nxt = 1'b1;
      end
      S_HWAIT: begin
        if (!head_q[LW-1]) begin
          rd_addr = head_q[EW-1:0];
          cur_nxt = head_q[EW-1:0];
        end else begin
          rd_addr        = free_r[EW-1:0];
          res_status_nxt = ST_NOTFOUND;
        end
      end
      S_WALK: begin
        if (key_hit) begin
          res_status_nxt = (cmd_r == CMD_INSERT) ? ST_DUP : ST_OK;
          res_slot_nxt   = {1'b0, cur_r};
          res_pred_nxt   = pred_r;
          res_link_nxt   = link_q;
          res_rec_nxt    = rec_q;
        end else if (link_q[LW-1] || steps_r == EW'(ENTRIES - 1)) begin
          pred_nxt       = {1'b0, cur_r};
          rd_addr        = free_r[EW-1:0];
          res_status_nxt = ST_NOTFOUND;
        end else begin
          pred_nxt  = {1'b0, cur_r};
          cur_nxt   = link_q[EW-1:0];
          rd_addr   = link_q[EW-1:0];
          steps_nxt = steps_r + 1'b1;
        end
      end
      S_FRESH: begin
        // link_q holds the next free entry below the stack top.
        cur_nxt        = free_r[EW-1:0];
        free_nxt       = link_q;
        count_nxt      = count_r + 1'b1;
        rec_we         = 1'b1;
        link_we        = 1'b1;
        link_wa        = free_r[EW-1:0];
        link_wd        = NULL_LINK;
        res_status_nxt = ST_OK;
        res_slot_nxt   = free_r;
        res_pred_nxt   = pred_r;
        res_link_nxt   = NULL_LINK;
        res_rec_nxt    = in_rec_r;
      end
      S_WR1: begin
        // Splice the chain: the predecessor, or the bucket head, takes the new link.
        if (pred_r[LW-1]) begin
          heads_we = 1'b1;
          heads_wd = (cmd_r == CMD_DELETE) ? res_link_r : {1'b0, cur_r};
        end else begin
          link_we = 1'b1;
          link_wa = pred_r[EW-1:0];
          link_wd = (cmd_r == CMD_DELETE) ? res_link_r : {1'b0, cur_r};
        end
      end
      S_WR2: begin
        link_we  = 1'b1;
        link_wa  = cur_r;
        link_wd  = free_r;
        free_nxt = {1'b0, cur_r};
        if (count_r != '0) count_nxt = count_r - 1'b1;
      end
      S_RESP: begin
        clr_resp_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (heads_we) heads_mem[heads_wa] <= heads_wd;
    if (link_we)  link_mem[link_wa]   <= link_wd;
    if (rec_we)   rec_mem[rec_wa]     <= in_rec_r;
    head_q <= heads_mem[bucket_r];
    link_q <= link_mem[rd_addr];
    rec_q  <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      clr_resp_r   <= 1'b0;
      free_r       <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      clr_resp_r <= clr_resp_nxt;
      free_r     <= free_nxt;
      count_r    <= count_nxt;
      if (state_r == S_RESP && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    in_rec_r     <= in_rec_nxt;
    bucket_r     <= bucket_nxt;
    hash_ph_r    <= hash_ph_nxt;
    prod_r       <= prod_nxt;
    cur_r        <= cur_nxt;
    pred_r       <= pred_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_pred_r   <= res_pred_nxt;
    res_link_r   <= res_link_nxt;
    res_rec_r    <= res_rec_nxt;
    if (state_r == S_RESP && out_free) begin
      out_tuser_r <= res_status_r;
      out_tdata_r <= {6'd0,
                      FILL_W'(count_r),
                      to_slot(res_link_r),
                      res_rec_r,
                      to_slot(res_pred_r),
                      to_slot(res_slot_r)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("record count above pool size");

  a_resp_before_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_RESP))
    else $error("result shown without a finished command");

  a_free_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && free_r[LW-1]) |-> count_r == CW'(ENTRIES))
    else $error("free stack empty with room in the pool");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && !key_hit && steps_r == EW'(ENTRIES - 1))
      |=> state_r != S_WALK)
    else $error("chain walk ran past pool size");
`endif

endmodule
`default_nettype wire

/* test/chained_hash_table_tb.sv */
// Testbench of the chained hash table: directed and random commands checked against a predictor.
`default_nettype none
module chained_hash_table_tb
  import chtbl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBUCKET = 16;
  localparam int NENTRY = 32;
  localparam int NONE = -1;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    status_t status;
    logic [5:0] slot;
    logic [5:0] prev_slot;
    logic [30:0] key;
    logic [2:0] role;
    logic [63:0] name0;
    logic [63:0] name1;
    logic [31:0] name2;
    logic [5:0] next_link;
    logic [5:0] fill;
  } reply_t;

  // Scoreboard: a software copy of the table and the replies it predicts.
  class table_scoreboard;
    int heads[NBUCKET];
    int links[NENTRY];
    logic [30:0] keys[NENTRY];
    logic [2:0] roles[NENTRY];
    logic [63:0] n0[NENTRY];
    logic [63:0] n1[NENTRY];
    logic [31:0] n2[NENTRY];
    int free_top;
    int count;
    reply_t pending[$];
    int errors;

    function void wipe();
      foreach (heads[i]) heads[i] = NONE;
      foreach (links[i]) links[i] = (i == NENTRY - 1) ? NONE : i + 1;
      free_top = 0;
      count = 0;
    endfunction

    // Walks the key's chain; returns the entry or -1 and the last entry passed.
    function int lookup(logic [30:0] k, output int pred);
      int cur;
      int steps;
      cur = heads[k % NBUCKET];
      pred = NONE;
      steps = 0;
      while (cur >= 0 && steps < NENTRY) begin
        if (keys[cur] == k) return cur;
        pred = cur;
        cur = links[cur];
        steps++;
      end
      return NONE;
    endfunction

    function reply_t make(status_t st, int s, int p, int l);
      reply_t r;
      r = '0;
      r.status = st;
      r.slot = s[5:0];
      r.prev_slot = (s >= 0) ? p[5:0] : 6'h3f;
      r.next_link = (s >= 0) ? l[5:0] : 6'h3f;
      if (s >= 0) begin
        r.key = keys[s];
        r.role = roles[s];
        r.name0 = n0[s];
        r.name1 = n1[s];
        r.name2 = n2[s];
      end
      r.fill = count[5:0];
      return r;
    endfunction

    function void note_command(cmd_t c, logic [30:0] k, logic [2:0] ro,
                               logic [63:0] a, logic [63:0] b, logic [31:0] d);
      int pred;
      int loc;
      int link;
      int fresh;
      case (c)
        CMD_CLEAR: begin
          wipe();
          pending.push_back(make(ST_OK, NONE, NONE, NONE));
        end
        CMD_INSERT: begin
          if (count >= NENTRY || free_top < 0) begin
            pending.push_back(make(ST_FULL, NONE, NONE, NONE));
          end else begin
            loc = lookup(k, pred);
            if (loc >= 0) begin
              pending.push_back(make(ST_DUP, loc, pred, links[loc]));
            end else begin
              fresh = free_top;
              free_top = links[fresh];
              count++;
              keys[fresh] = k;
              roles[fresh] = ro;
              n0[fresh] = a;
              n1[fresh] = b;
              n2[fresh] = d;
              links[fresh] = NONE;
              if (pred >= 0) links[pred] = fresh;
              else heads[k % NBUCKET] = fresh;
              pending.push_back(make(ST_OK, fresh, pred, NONE));
            end
          end
        end
        default: begin
          loc = lookup(k, pred);
          if (loc < 0) begin
            pending.push_back(make(ST_NOTFOUND, NONE, NONE, NONE));
          end else begin
            link = links[loc];
            if (c == CMD_DELETE) begin
              if (pred >= 0) links[pred] = link;
              else heads[k % NBUCKET] = link;
              links[loc] = free_top;
              free_top = loc;
              if (count > 0) count--;
            end
            pending.push_back(make(ST_OK, loc, pred, link));
          end
        end
      endcase
    endfunction

    function void check_reply(logic [1:0] st, logic [OUT_DATA_W-1:0] d);
      reply_t e;
      if (pending.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st); errors++;
      end
      if (d[5:0] !== e.slot) begin
        $error("slot: expected %0d, actual %0d", e.slot, d[5:0]); errors++;
      end
      if (d[11:6] !== e.prev_slot) begin
        $error("prev_slot: expected %0d, actual %0d", e.prev_slot, d[11:6]); errors++;
      end
      if (d[42:12] !== e.key) begin
        $error("found_key: expected %h, actual %h", e.key, d[42:12]); errors++;
      end
      if (d[45:43] !== e.role) begin
        $error("found_role: expected %h, actual %h", e.role, d[45:43]); errors++;
      end
      if (d[109:46] !== e.name0) begin
        $error("found_name0: expected %h, actual %h", e.name0, d[109:46]); errors++;
      end
      if (d[173:110] !== e.name1) begin
        $error("found_name1: expected %h, actual %h", e.name1, d[173:110]); errors++;
      end
      if (d[205:174] !== e.name2) begin
        $error("found_name2: expected %h, actual %h", e.name2, d[205:174]); errors++;
      end
      if (d[211:206] !== e.next_link) begin
        $error("next_link: expected %0d, actual %0d", e.next_link, d[211:206]); errors++;
      end
      if (d[217:212] !== e.fill) begin
        $error("fill_count: expected %0d, actual %0d", e.fill, d[217:212]); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  table_scoreboard sb;
  bit calm;              // when set, neither side idles
  int quiet_cycles = 0;  // cycles in a row with no handshake
  logic [30:0] used_keys[$];

  chained_hash_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // The receiver stalls at random; results are checked at the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_reply(out_tuser, out_tdata);
      out_tready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // Watchdog: ends the run after a long stretch with no accepted item.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one command, idling at random first, and returns once it is accepted.
  task automatic send(cmd_t c, logic [30:0] k, logic [2:0] ro,
                      logic [63:0] a, logic [63:0] b, logic [31:0] d);
    while (!calm && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {6'd0, d, b, a, ro, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(c, k, ro, a, b, d);
    if (c == CMD_INSERT) used_keys.push_back(k);
  endtask

  task automatic send_random_name(cmd_t c, logic [30:0] k);
    send(c, k, 3'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Picks a key: mostly ones already used, sometimes new, often in few buckets.
  function automatic logic [30:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 55 && used_keys.size() != 0)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    if (r < 85) return 31'($urandom_range(3) * NBUCKET + $urandom_range(2));
    return 31'($urandom);
  endfunction

  initial begin
    int i;
    int n;
    int r;
    sb = new();
    sb.wipe();
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_CLEAR;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, every command and each special case.
    send(CMD_SEARCH, 31'd5, 3'd0, '0, '0, '0);
    send(CMD_DELETE, 31'd5, 3'd0, '0, '0, '0);
    send(CMD_INSERT, 31'h7fffffff, 3'd7, '1, '1, '1);
    send(CMD_INSERT, 31'd0, 3'd0, '0, '0, '0);
    send(CMD_INSERT, 31'd16, 3'd1, 64'h0123456789abcdef, 64'hfedcba9876543210, 32'h55aa55aa);
    send(CMD_INSERT, 31'd32, 3'd4, '1, '0, 32'h0);
    send(CMD_INSERT, 31'd16, 3'd2, '0, '0, '0);
    send(CMD_SEARCH, 31'd32, 3'd0, '0, '0, '0);
    send(CMD_DELETE, 31'd16, 3'd0, '0, '0, '0);
    send(CMD_SEARCH, 31'd32, 3'd0, '0, '0, '0);
    send(CMD_DELETE, 31'd0, 3'd0, '0, '0, '0);
    send(CMD_SEARCH, 31'h7fffffff, 3'd0, '0, '0, '0);
    // Fill the rest of the pool in one bucket, then overflow it.
    for (i = 0; i < NENTRY; i++) send_random_name(CMD_INSERT, 31'(i * NBUCKET + 3));
    send_random_name(CMD_INSERT, 31'd3);
    send_random_name(CMD_INSERT, 31'd999);
    send(CMD_SEARCH, 31'((NENTRY - 1) * NBUCKET + 3), 3'd0, '0, '0, '0);
    // The sender holds off until every expected result has come.
    drain();
    send(CMD_CLEAR, '1, '1, '1, '1, '1);
    used_keys.delete();

    // Random part, with a calm stretch in the middle.
    n = 0;
    while (n < 800) begin
      calm = (n >= 300 && n < 400);
      r = $urandom_range(99);
      if (r < 2) begin
        send_random_name(CMD_CLEAR, 31'($urandom));
        used_keys.delete();
      end else if (r < 50) send_random_name(CMD_INSERT, pick_key());
      else if (r < 72) send_random_name(CMD_DELETE, pick_key());
      else send_random_name(CMD_SEARCH, pick_key());
      n++;
    end
    calm = 1'b0;
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
